@@ design/qse_pkg.sv @@
// qse_pkg: shared types for the quicksort engine
// beat payload structs, sequencer states and the emit status group
// no dependencies
package qse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     truncated;
  } result_t;

  // status of the beat shown on the result port; data comes from the store
  typedef struct packed {
    logic valid;
    logic end_of_set;
    logic truncated;
  } emit_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SORT_INIT,
    S_POP,
    S_POP_WAIT,
    S_PIVOT,
    S_SCAN_I,
    S_SCAN_I_WAIT,
    S_SCAN_J,
    S_SCAN_J_WAIT,
    S_CHECK,
    S_SWAP_J,
    S_PLACE_J,
    S_PUSH_A,
    S_PUSH_B,
    S_EMIT,
    S_DRAIN
  } state_t;

endpackage

@@ design/qse_ram.sv @@
// qse_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no reset of contents
// no dependencies
module qse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/qse_ctrl.sv @@
// qse_ctrl: load, partition and emit sequencer for the quicksort engine
// drives the element store and the range stack; one access per cycle each
// depends on qse_pkg
module qse_ctrl #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  qse_pkg::in_item_t                      item,
  output logic                                   busy,
  output qse_pkg::emit_t                         emit,
  output logic                                   st_we,
  output logic [$clog2(CAPACITY)-1:0]            st_waddr,
  output logic [qse_pkg::DATA_W-1:0]             st_wdata,
  output logic [$clog2(CAPACITY)-1:0]            st_raddr,
  input  logic [qse_pkg::DATA_W-1:0]             st_rdata,
  output logic                                   sk_we,
  output logic [$clog2(CAPACITY)-1:0]            sk_waddr,
  output logic [2*$clog2(CAPACITY)-1:0]          sk_wdata,
  output logic [$clog2(CAPACITY)-1:0]            sk_raddr,
  input  logic [2*$clog2(CAPACITY)-1:0]          sk_rdata
);

  import qse_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic              ovf, ovf_next;
  logic [CW-1:0]     sp, sp_next;
  logic [IW-1:0]     lo, lo_next, hi, hi_next, j, j_next, k, k_next;
  logic [CW-1:0]     i, i_next;
  logic [DATA_W-1:0] p, p_next, vi, vi_next, vj, vj_next;
  emit_t             emit_next;

  logic          rd_le_p;
  logic          left_ok, right_ok, left_first;
  logic [IW-1:0] lsz, rsz;
  logic          push_ok;

  assign rd_le_p    = $signed(st_rdata) <= $signed(p);
  assign left_ok    = j > lo;
  assign right_ok   = j < hi;
  assign lsz        = left_ok ? (j - lo - IW'(1)) : '0;
  assign rsz        = right_ok ? (hi - j - IW'(1)) : '0;
  assign left_first = lsz >= rsz;
  assign push_ok    = sp < CAP;
  assign busy       = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      sp    <= '0;
      emit  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      sp    <= sp_next;
      emit  <= emit_next;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    i  <= i_next;
    j  <= j_next;
    k  <= k_next;
    p  <= p_next;
    vi <= vi_next;
    vj <= vj_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    sp_next    = sp;
    lo_next    = lo;
    hi_next    = hi;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    p_next     = p;
    vi_next    = vi;
    vj_next    = vj;
    emit_next  = '0;
    st_we      = 1'b0;
    st_waddr   = '0;
    st_wdata   = '0;
    st_raddr   = '0;
    sk_we      = 1'b0;
    sk_waddr   = sp[IW-1:0];
    sk_wdata   = '0;
    sk_raddr   = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (count < CAP) begin
            st_we      = 1'b1;
            st_waddr   = count[IW-1:0];
            st_wdata   = item.value;
            count_next = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (item.last) begin
            state_next = S_SORT_INIT;
          end
        end
      end
      S_SORT_INIT: begin
        sp_next = '0;
        k_next  = '0;
        if (count < CW'(2)) begin
          state_next = S_EMIT;
        end else begin
          sk_we      = 1'b1;
          sk_waddr   = '0;
          sk_wdata   = {IW'(0), IW'(count - CW'(1))};
          sp_next    = CW'(1);
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (sp == '0) begin
          k_next     = '0;
          state_next = S_EMIT;
        end else begin
          sk_raddr   = IW'(sp - CW'(1));
          sp_next    = sp - CW'(1);
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        lo_next = sk_rdata[2*IW-1:IW];
        hi_next = sk_rdata[IW-1:0];
        i_next  = CW'(sk_rdata[2*IW-1:IW]) + CW'(1);
        j_next  = sk_rdata[IW-1:0];
        if (sk_rdata[2*IW-1:IW] >= sk_rdata[IW-1:0]) begin
          state_next = S_POP;
        end else begin
          st_raddr   = sk_rdata[2*IW-1:IW];
          state_next = S_PIVOT;
        end
      end
      S_PIVOT: begin
        p_next     = st_rdata;
        state_next = S_SCAN_I;
      end
      S_SCAN_I: begin
        if (i <= CW'(hi)) begin
          st_raddr   = i[IW-1:0];
          state_next = S_SCAN_I_WAIT;
        end else begin
          state_next = S_SCAN_J;
        end
      end
      S_SCAN_I_WAIT: begin
        if (rd_le_p) begin
          i_next     = i + CW'(1);
          state_next = S_SCAN_I;
        end else begin
          vi_next    = st_rdata;
          state_next = S_SCAN_J;
        end
      end
      S_SCAN_J: begin
        if (j > lo) begin
          st_raddr   = j;
          state_next = S_SCAN_J_WAIT;
        end else begin
          // scan bottomed out on the pivot slot itself
          vj_next    = p;
          state_next = S_CHECK;
        end
      end
      S_SCAN_J_WAIT: begin
        if (!rd_le_p) begin
          j_next     = j - IW'(1);
          state_next = S_SCAN_J;
        end else begin
          vj_next    = st_rdata;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        st_we = 1'b1;
        if (i < CW'(j)) begin
          st_waddr   = i[IW-1:0];
          st_wdata   = vj;
          state_next = S_SWAP_J;
        end else begin
          // pivot lands at j: element from j goes to the range head
          st_waddr   = lo;
          st_wdata   = vj;
          state_next = S_PLACE_J;
        end
      end
      S_SWAP_J: begin
        st_we      = 1'b1;
        st_waddr   = j;
        st_wdata   = vi;
        state_next = S_SCAN_I;
      end
      S_PLACE_J: begin
        st_we      = 1'b1;
        st_waddr   = j;
        st_wdata   = p;
        state_next = S_PUSH_A;
      end
      S_PUSH_A: begin
        // larger part goes on first so the smaller one is popped next
        if (left_first ? left_ok : right_ok) begin
          if (push_ok) begin
            sk_we   = 1'b1;
            sp_next = sp + CW'(1);
          end
          sk_wdata = left_first ? {lo, j - IW'(1)} : {j + IW'(1), hi};
        end
        state_next = S_PUSH_B;
      end
      S_PUSH_B: begin
        if (left_first ? right_ok : left_ok) begin
          if (push_ok) begin
            sk_we   = 1'b1;
            sp_next = sp + CW'(1);
          end
          sk_wdata = left_first ? {j + IW'(1), hi} : {lo, j - IW'(1)};
        end
        state_next = S_POP;
      end
      S_EMIT: begin
        st_raddr             = k;
        emit_next.valid      = 1'b1;
        emit_next.truncated  = ovf;
        emit_next.end_of_set = (CW'(k) + CW'(1)) == count;
        if ((CW'(k) + CW'(1)) == count) begin
          state_next = S_DRAIN;
        end else begin
          k_next = k + IW'(1);
        end
      end
      S_DRAIN: begin
        count_next = '0;
        ovf_next   = 1'b0;
        sp_next    = '0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !emit.valid)
    else $error("result beat while idle");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CAP)
    else $error("range stack depth past capacity");

  a_sort_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT_INIT) |-> (count != '0) && (count <= CAP))
    else $error("sort started on an empty or oversized set");

  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_J_WAIT) |-> (j > lo) && (j <= hi))
    else $error("downward scan outside its range");

  a_last_then_drain: assert property (@(posedge clk) disable iff (rst)
    (emit_next.valid && emit_next.end_of_set) |=> (state == S_DRAIN))
    else $error("final beat not followed by drain");

endmodule

@@ design/quicksort_engine_top.sv @@
// quicksort_engine_top: loads a set, sorts it in place with quicksort, emits it
// load: one beat per cycle while busy is low; the last beat raises busy until the set is out
// sort: time grows with the ranges popped, the elements the scans read and the swaps;
// ordered or flat sets take far longer than scattered ones
// emit: N result beats on consecutive cycles, each registered from a store read in the emit state; busy
// drops the cycle after the final beat. sync reset: idle, empty set, ram contents kept
module quicksort_engine_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  qse_pkg::in_item_t item,
  output logic              busy,
  output logic              done,
  output qse_pkg::result_t  result
);

  import qse_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);

  emit_t             emit;
  logic              st_we, sk_we;
  logic [IW-1:0]     st_waddr, st_raddr, sk_waddr, sk_raddr;
  logic [DATA_W-1:0] st_wdata, st_rdata;
  logic [2*IW-1:0]   sk_wdata, sk_rdata;

  qse_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .emit     (emit),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .sk_we    (sk_we),
    .sk_waddr (sk_waddr),
    .sk_wdata (sk_wdata),
    .sk_raddr (sk_raddr),
    .sk_rdata (sk_rdata)
  );

  qse_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qse_ram #(.WIDTH(2*IW), .DEPTH(CAPACITY)) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  assign done                = emit.valid;
  assign result.sorted_value = st_rdata;
  assign result.end_of_set   = emit.end_of_set;
  assign result.truncated    = emit.truncated;

endmodule

@@ tb/sv/quicksort_engine_top_tb.sv @@
// quicksort_engine_top_tb: self-checking bench for the quicksort engine
// loads sets through the start/busy port, predicts the sorted beats and checks them
// depends on qse_pkg and quicksort_engine_top
module quicksort_engine_top_tb;
  import qse_pkg::*;

  localparam int unsigned SET_CAPACITY = 64;
  localparam int unsigned RUN_LIMIT    = 1000000;
  localparam int unsigned ITEM_TARGET  = 290;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic signed [31:0] MAX_VAL = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_VAL = 32'sh80000000;

  typedef enum logic [1:0] {
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_FLAT,
    SHAPE_SCATTER
  } set_shape_t;

  // holds the set being loaded and the sorted beats still owed by the block
  class sorted_set_checker;
    int unsigned        capacity;
    logic signed [31:0] held[$];
    bit                 dropped;
    result_t            sorted_due[$];
    int unsigned        errors;

    function new(int unsigned cap);
      capacity = cap;
      dropped  = 1'b0;
      errors   = 0;
    endfunction

    function void note_beat(in_item_t beat);
      logic signed [31:0] key;
      int                 i;
      int                 j;
      result_t            r;
      if (held.size() < capacity) held.push_back(beat.value);
      else dropped = 1'b1;
      if (!beat.last) return;
      for (i = 1; i < held.size(); i++) begin
        key = held[i];
        j = i;
        while (j > 0 && held[j-1] > key) begin
          held[j] = held[j-1];
          j--;
        end
        held[j] = key;
      end
      for (i = 0; i < held.size(); i++) begin
        r.sorted_value = held[i];
        r.end_of_set   = (i == held.size() - 1);
        r.truncated    = dropped;
        sorted_due.push_back(r);
      end
      held.delete();
      dropped = 1'b0;
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (sorted_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: value %0d eos %0b trunc %0b",
                   got.sorted_value, got.end_of_set, got.truncated);
        return;
      end
      want = sorted_due.pop_front();
      if (got.sorted_value !== want.sorted_value || got.end_of_set !== want.end_of_set ||
          got.truncated !== want.truncated) begin
        errors++;
        if (errors <= 10)
          $display({"result beat differs: expected value %0d eos %0b trunc %0b, ",
                    "got value %0d eos %0b trunc %0b"},
                   want.sorted_value, want.end_of_set, want.truncated,
                   got.sorted_value, got.end_of_set, got.truncated);
      end
    endfunction
  endclass

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  in_item_t item  = '0;
  logic     busy;
  logic     done;
  result_t  result;

  int unsigned       cycle_count = 0;
  int unsigned       items_sent  = 0;
  int unsigned       idle_pct    = 31;
  sorted_set_checker order_check = new(SET_CAPACITY);

  quicksort_engine_top #(.CAPACITY(SET_CAPACITY)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // input beat taken on start && !busy, result beat on done
  always @(posedge clk) begin
    if (!rst && start && !busy) order_check.note_beat(item);
  end

  always @(posedge clk) begin
    if (!rst && done) order_check.check_beat(result);
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      5, 6:    return $signed($urandom_range(0, 8)) - 4;
      7: begin
        case ($urandom_range(0, 3))
          0:       return MAX_VAL;
          1:       return MIN_VAL;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      8:       return MIN_VAL + $signed($urandom_range(0, 3));
      9:       return MAX_VAL - $signed($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic signed [31:0] v, input logic l);
    if (items_sent < 100) idle_pct = 31;
    else if (items_sent < 200) idle_pct = 79;
    else idle_pct = 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= '{value: v, last: l};
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // hold the sender off until every owed beat has come back
  task automatic drain_pause();
    start <= 1'b0;
    @(posedge clk);
    while (order_check.sorted_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_set(input logic signed [31:0] vals[$]);
    int k;
    for (k = 0; k < vals.size(); k++) send_beat(vals[k], k == vals.size() - 1);
  endtask

  initial begin
    int unsigned        set_len;
    int unsigned        k;
    set_shape_t         shape;
    logic signed [31:0] base;
    logic signed [31:0] v;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed sets: single extremes, mixed extremes with repeats, flat, falling, rising
    send_set('{MAX_VAL});
    send_set('{MIN_VAL});
    send_set('{32'sd0, -32'sd1, MAX_VAL, MIN_VAL, 32'sd1, MAX_VAL, MIN_VAL});
    send_set('{32'sd5, 32'sd5, 32'sd5, 32'sd5});
    send_set('{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2});
    send_set('{-32'sd3, -32'sd1, 32'sd2, 32'sd7, 32'sd100});
    drain_pause();

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       set_len = $urandom_range(SET_CAPACITY, SET_CAPACITY + 6);
        1:       set_len = 1;
        default: set_len = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 7))
        0:       shape = SHAPE_RISING;
        1:       shape = SHAPE_FALLING;
        2:       shape = SHAPE_FLAT;
        default: shape = SHAPE_SCATTER;
      endcase
      base = pick_value();
      for (k = 0; k < set_len; k++) begin
        case (shape)
          SHAPE_RISING:  v = base + $signed(k);
          SHAPE_FALLING: v = base - $signed(k);
          SHAPE_FLAT:    v = base;
          default:       v = pick_value();
        endcase
        send_beat(v, k == set_len - 1);
      end
      if ($urandom_range(0, 5) == 0) drain_pause();
    end

    drain_pause();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (order_check.errors == 0) $display("quicksort_engine_top: match");
    else $display("quicksort_engine_top: mismatch");
    $finish;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("quicksort_engine_top: mismatch");
    $finish;
  end

endmodule

@@ quicksort_engine_top.f @@
design/qse_pkg.sv
design/qse_ram.sv
design/qse_ctrl.sv
design/quicksort_engine_top.sv
tb/sv/quicksort_engine_top_tb.sv
